// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the entity decoder. Every user has clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

// ===== rtl/xeu_pkg.sv =====
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared types, escape tables and constants of the XML entity decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xeu_pkg;

  // Depth of the run queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] ChAmp = 8'h26;

  // Escape being matched after an ampersand
  typedef enum logic [2:0] {
    ESC_LT   = 3'd0,
    ESC_GT   = 3'd1,
    ESC_QUOT = 3'd2,
    ESC_AMP  = 3'd3,
    ESC_NUM  = 3'd4
  } esc_id_e;

  // One run of output bytes caused by one input item:
  // optional '&' + body bytes, optional middle byte, optional trailing '&'
  typedef struct packed {
    logic       lead_amp;
    esc_id_e    body_id;
    logic [2:0] body_cnt;
    logic       mid_en;
    logic [7:0] mid_byte;
    logic       tail_amp;
    logic       stream_end;
  } run_desc_t;

  // Body byte idx of an escape (text after the ampersand)
  function automatic logic [7:0] esc_body(esc_id_e id, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (id)
      ESC_LT: begin
        unique case (idx)
          3'd0:    ch = "l";
          3'd1:    ch = "t";
          3'd2:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      ESC_GT: begin
        unique case (idx)
          3'd0:    ch = "g";
          3'd1:    ch = "t";
          3'd2:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      ESC_QUOT: begin
        unique case (idx)
          3'd0:    ch = "q";
          3'd1:    ch = "u";
          3'd2:    ch = "o";
          3'd3:    ch = "t";
          3'd4:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      ESC_AMP: begin
        unique case (idx)
          3'd0:    ch = "a";
          3'd1:    ch = "m";
          3'd2:    ch = "p";
          3'd3:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      ESC_NUM: begin
        unique case (idx)
          3'd0:    ch = "#";
          3'd1:    ch = "0";
          3'd2:    ch = "3";
          3'd3:    ch = "9";
          3'd4:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Body length of an escape; zero for codes that name no escape
  function automatic logic [2:0] esc_len(esc_id_e id);
    logic [2:0] len;
    unique case (id)
      ESC_LT:   len = 3'd3;
      ESC_GT:   len = 3'd3;
      ESC_QUOT: len = 3'd5;
      ESC_AMP:  len = 3'd4;
      ESC_NUM:  len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  // Decoded character of an escape
  function automatic logic [7:0] esc_char(esc_id_e id);
    logic [7:0] ch;
    unique case (id)
      ESC_LT:   ch = "<";
      ESC_GT:   ch = ">";
      ESC_QUOT: ch = 8'h22;
      ESC_AMP:  ch = ChAmp;
      ESC_NUM:  ch = 8'h27;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/xeu_front.sv =====
// ----------------------------------------------------------------------------
// xeu_front
// Accepts input bytes, tracks the pending escape and emits one run
// descriptor per item that produces output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module xeu_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               end_of_data_i,
  input  wire logic               q_full_i,
  output xeu_pkg::run_desc_t      desc_o,
  output logic                    desc_push_o
);
  import xeu_pkg::*;

  logic       open_q, open_d;
  esc_id_e    id_q, id_d;
  logic [2:0] cnt_q, cnt_d;

  logic       accept;
  logic       hit;
  esc_id_e    hit_id;
  logic       cont_ok;
  logic [2:0] cnt_inc;
  logic       has_out;
  run_desc_t  desc;

  assign accept  = item_valid_i && !q_full_i;
  assign cnt_inc = cnt_q + 3'd1;

  // First body byte selects the escape
  always_comb begin
    hit    = 1'b1;
    hit_id = ESC_LT;
    unique case (in_byte_i)
      "l":     hit_id = ESC_LT;
      "g":     hit_id = ESC_GT;
      "q":     hit_id = ESC_QUOT;
      "a":     hit_id = ESC_AMP;
      "#":     hit_id = ESC_NUM;
      default: hit = 1'b0;
    endcase
  end

  // Next body byte of a partial match
  assign cont_ok = (cnt_q < esc_len(id_q)) && (esc_body(id_q, cnt_q) == in_byte_i);

  // Classify the byte: next escape state and the run it produces
  always_comb begin
    open_d = open_q;
    id_d   = id_q;
    cnt_d  = cnt_q;
    desc   = '0;

    if (!open_q) begin
      if (in_byte_i == ChAmp) begin
        open_d = 1'b1;
        id_d   = ESC_LT;
        cnt_d  = 3'd0;
      end else begin
        desc.mid_en   = 1'b1;
        desc.mid_byte = in_byte_i;
      end
    end else if (cnt_q == 3'd0) begin
      if (hit) begin
        id_d  = hit_id;
        cnt_d = 3'd1;
      end else begin
        // no escape starts here: '&' and the byte go out literally
        desc.lead_amp = 1'b1;
        desc.mid_en   = 1'b1;
        desc.mid_byte = in_byte_i;
        open_d        = 1'b0;
        id_d          = ESC_LT;
        cnt_d         = 3'd0;
      end
    end else if (cont_ok) begin
      if (cnt_inc == esc_len(id_q)) begin
        desc.mid_en   = 1'b1;
        desc.mid_byte = esc_char(id_q);
        open_d        = 1'b0;
        id_d          = ESC_LT;
        cnt_d         = 3'd0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else begin
      // broken partial match: flush it, then treat the byte as plain
      desc.lead_amp = 1'b1;
      desc.body_id  = id_q;
      desc.body_cnt = (esc_len(id_q) != 3'd0) ? cnt_q : 3'd0;
      id_d          = ESC_LT;
      cnt_d         = 3'd0;
      if (in_byte_i == ChAmp) begin
        open_d = 1'b1;
      end else begin
        open_d        = 1'b0;
        desc.mid_en   = 1'b1;
        desc.mid_byte = in_byte_i;
      end
    end

    // End of data flushes whatever is still pending
    if (end_of_data_i) begin
      if (open_d) begin
        if (desc.lead_amp) begin
          desc.tail_amp = 1'b1;
        end else begin
          desc.lead_amp = 1'b1;
          desc.body_id  = id_d;
          desc.body_cnt = cnt_d;
        end
      end
      desc.stream_end = 1'b1;
      open_d          = 1'b0;
      id_d            = ESC_LT;
      cnt_d           = 3'd0;
    end
  end

  assign has_out     = desc.lead_amp || desc.mid_en || desc.tail_amp;
  assign desc_o      = desc;
  assign desc_push_o = accept && has_out;

  // Escape state, updated on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      id_q   <= ESC_LT;
      cnt_q  <= 3'd0;
    end else if (accept) begin
      open_q <= open_d;
      id_q   <= id_d;
      cnt_q  <= cnt_d;
    end
  end

  `ASSERT_PROP(a_closed_is_clean, !open_q |-> (cnt_q == 3'd0 && id_q == ESC_LT),
               "closed escape holds stale match state")
  `ASSERT_PROP(a_partial_in_range, (open_q && cnt_q != 3'd0) |-> (cnt_q < esc_len(id_q)),
               "partial match count reaches escape length")

endmodule

`default_nettype wire

// ===== rtl/xeu_queue.sv =====
// ----------------------------------------------------------------------------
// xeu_queue
// Short FIFO of run descriptors between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module xeu_queue #(
  parameter int unsigned Depth = xeu_pkg::QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire xeu_pkg::run_desc_t wdata_i,
  input  wire logic               pop_i,
  output xeu_pkg::run_desc_t      head_o,
  output logic                    empty_o,
  output logic                    full_o
);
  import xeu_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_desc_t       mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [IdxW-1:0] ptr_next(logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_PROP(a_count_bound, count_q <= CntW'(Depth), "queue fill count beyond depth")

endmodule

`default_nettype wire

// ===== rtl/xeu_back.sv =====
// ----------------------------------------------------------------------------
// xeu_back
// Walks the head run into the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module xeu_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire xeu_pkg::run_desc_t head_i,
  input  wire logic               head_valid_i,
  output logic                    head_pop_o,
  output logic [7:0]              out_byte_o,
  output logic                    last_of_run_o,
  output logic                    stream_end_o,
  output logic                    empty_o,
  input  wire logic               pop_i
);
  import xeu_pkg::*;

  logic [2:0] pos_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q, end_q;

  logic [3:0] total;
  logic [3:0] mid_pos;
  logic [2:0] body_idx;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       step;

  // Run length and position of the middle byte
  assign mid_pos  = {3'b000, head_i.lead_amp} + {1'b0, head_i.body_cnt};
  assign total    = mid_pos + {3'b000, head_i.mid_en} + {3'b000, head_i.tail_amp};
  assign body_idx = pos_q - {2'b00, head_i.lead_amp};
  assign cur_last = ({1'b0, pos_q} + 4'd1) == total;

  // Byte at the current position of the run
  always_comb begin
    if (head_i.lead_amp && pos_q == 3'd0) begin
      cur_byte = ChAmp;
    end else if (head_i.lead_amp && body_idx < head_i.body_cnt) begin
      cur_byte = esc_body(head_i.body_id, body_idx);
    end else if (head_i.mid_en && {1'b0, pos_q} == mid_pos) begin
      cur_byte = head_i.mid_byte;
    end else begin
      cur_byte = ChAmp;
    end
  end

  // Advance when the output register is free or being drained
  assign step       = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o = step && cur_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
      pos_q       <= cur_last ? 3'd0 : pos_q + 3'd1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= cur_byte;
      last_q     <= cur_last;
      end_q      <= cur_last && head_i.stream_end;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign stream_end_o  = end_q;

  `ASSERT_PROP(a_pos_in_run, head_valid_i |-> ({1'b0, pos_q} < total),
               "run position beyond run length")
  `ASSERT_PROP(a_end_is_last, (out_valid_q && end_q) |-> last_q,
               "stream end flagged on a byte that does not end its run")

endmodule

`default_nettype wire

// ===== rtl/xml_entity_unescape.sv =====
// Path: a run from an accepted byte goes through the run queue, then into the output register.
// Throughput: one input per cycle while the run queue has room; a run of n results leaves the
// output register one byte per pop, absorbed by the run queue (QueueDepth entries).
// Input stalls (full) only when the run queue is full.
// Reset: asynchronous, active low; clears the pending escape, queue and output valid.
// ----------------------------------------------------------------------------
// xml_entity_unescape
// Decodes &lt; &gt; &quot; &amp; &#039; in a byte stream; other bytes pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_unescape #(
  parameter int unsigned QueueDepth = xeu_pkg::QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_data_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            stream_end_o
);
  import xeu_pkg::*;

  run_desc_t desc, head;
  logic      desc_push, head_pop, q_empty, q_full;

  // Front: classify bytes and track the pending escape
  xeu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (push),
    .in_byte_i     (in_byte_i),
    .end_of_data_i (end_of_data_i),
    .q_full_i      (q_full),
    .desc_o        (desc),
    .desc_push_o   (desc_push)
  );

  // Run queue
  xeu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc),
    .pop_i   (head_pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back: emit runs byte by byte
  xeu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (!q_empty),
    .head_pop_o    (head_pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_end_o  (stream_end_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

  assign full = q_full;

endmodule

`default_nettype wire

// ===== tb/xml_entity_unescape_tb.sv =====
// ----------------------------------------------------------------------------
// xml_entity_unescape_tb
// Self-checking bench for the entity decoder. A short directed byte stream
// hits &quot;, &gt; and the literal-copy, broken-match and end-flush paths.
// Random token streams follow, 40 percent well-formed escapes. A scoreboard
// predicts every decoded byte and checks the popped results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xml_entity_unescape_tb;

  import xeu_pkg::*;

  // One decoded byte as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_last;
  } decoded_t;

  // Decoder prediction and queue of decoded bytes still to be popped
  class entity_scoreboard;
    decoded_t    decoded_q[$];
    logic [7:0]  run_q[$];
    logic        amp_pending;
    esc_id_e     entity;
    logic [2:0]  matched;
    int unsigned errors;

    function new();
      errors = 0;
      close_escape();
    endfunction

    // Escape text after the ampersand
    static function string escape_body(int id);
      case (id)
        ESC_LT:   return "lt;";
        ESC_GT:   return "gt;";
        ESC_QUOT: return "quot;";
        ESC_AMP:  return "amp;";
        ESC_NUM:  return "#039;";
        default:  return "";
      endcase
    endfunction

    function void close_escape();
      amp_pending = 1'b0;
      entity      = ESC_LT;
      matched     = 3'd0;
    endfunction

    // Byte outside an escape: an ampersand opens one, anything else copies
    function void open_or_copy(logic [7:0] b);
      if (b == ChAmp) begin
        amp_pending = 1'b1;
        entity      = ESC_LT;
        matched     = 3'd0;
      end else begin
        run_q.push_back(b);
      end
    endfunction

    // Pending ampersand and matched body go out literally
    function void flush_literal();
      string txt;
      txt = escape_body(entity);
      run_q.push_back(ChAmp);
      for (int i = 0; i < matched; i++) run_q.push_back(txt[i]);
      close_escape();
    endfunction

    // Accepted input transfer: append the decoded bytes it causes
    function void note_input(logic [7:0] b, logic eod);
      string    txt;
      string    glyphs;
      int       found;
      decoded_t r;
      glyphs = "<>\"&'";
      run_q.delete();
      if (!amp_pending) begin
        open_or_copy(b);
      end else if (matched == 3'd0) begin
        found = -1;
        for (int i = 0; i < 5; i++) begin
          txt = escape_body(i);
          if (found < 0 && txt[0] == b) found = i;
        end
        if (found >= 0) begin
          entity  = esc_id_e'(found);
          matched = 3'd1;
        end else begin
          // no escape starts here: both bytes copied, even a second ampersand
          run_q.push_back(ChAmp);
          run_q.push_back(b);
          close_escape();
        end
      end else begin
        txt = escape_body(entity);
        if (txt[matched] == b) begin
          matched = matched + 3'd1;
          if (matched == txt.len()) begin
            run_q.push_back(glyphs[entity]);
            close_escape();
          end
        end else begin
          flush_literal();
          open_or_copy(b);
        end
      end
      if (eod) begin
        if (amp_pending) flush_literal();
        close_escape();
      end
      for (int k = 0; k < run_q.size(); k++) begin
        r.data        = run_q[k];
        r.run_last    = (k == run_q.size() - 1);
        r.stream_last = r.run_last && eod;
        decoded_q.push_back(r);
      end
    endfunction

    // Popped result transfer against the oldest predicted byte
    function void check_result(decoded_t got);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h last %b end %b",
                 $time, got.data, got.run_last, got.stream_last);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      if (got.data != want.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
        errors++;
      end
      if (got.run_last != want.run_last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, want.run_last,
                 got.run_last);
        errors++;
      end
      if (got.stream_last != want.stream_last) begin
        $display("%0t: stream_end expected %b actual %b", $time, want.stream_last,
                 got.stream_last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic       full;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_data_i = 1'b0;
  logic       empty;
  logic       pop           = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       stream_end_o;

  entity_scoreboard sb = new();

  int unsigned burst_left = 0;
  bit          no_idle    = 1'b1;
  int unsigned sent       = 0;
  int unsigned rx_cycle   = 0;

  xml_entity_unescape dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .end_of_data_i (end_of_data_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_end_o  (stream_end_o)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("xml_entity_unescape verification failed");
    $finish;
  end

  // One input transfer; bursts end in a random gap unless idling is off
  task automatic send_item(input logic [7:0] b, input logic eod);
    if (!no_idle && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    push          <= 1'b1;
    in_byte_i     <= b;
    end_of_data_i <= eod;
    do @(posedge clk_i); while (full);
    sb.note_input(b, eod);
    if (burst_left != 0) burst_left--;
    sent++;
  endtask

  task automatic send_text(input string s, input logic eod_on_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], eod_on_last && (i == s.len() - 1));
  endtask

  // Hold off input until every predicted byte has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: check popped transfers, stall on a rotating pattern
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result({out_byte_o, last_of_run_o, stream_end_o});
      rx_cycle++;
      case (rx_cycle[8:7])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= ($urandom_range(0, 3) != 0);
        2'd2:    pop <= ($urandom_range(0, 3) == 0);
        default: pop <= rx_cycle[3];
      endcase
    end
  end

  // Stimulus
  initial begin
    int          pick;
    int          id;
    int          cut;
    string       body;
    logic [7:0]  b;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full escape, literal copies, broken matches, end flushes
    send_text("&quot;", 1'b0);
    send_text("&x", 1'b0);
    send_text("&&", 1'b0);
    send_text("&qu!", 1'b0);
    send_text("&am&gt;", 1'b1);
    send_text("&#0", 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    wait_drained();

    // random token stream
    while (sent < 530) begin
      if (sent > 130) no_idle = 1'b0;
      if (sent > 300 && sent < 310) wait_drained();
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, 4);
      body = entity_scoreboard::escape_body(id);
      if (pick < 40) begin
        send_item(ChAmp, 1'b0);
        send_text(body, 1'b0);
      end else if (pick < 60) begin
        b = 8'($urandom_range(0, 255));
        if (b == ChAmp) b = 8'h3B;
        send_item(b, 1'b0);
      end else if (pick < 70) begin
        // partial escape broken by a random byte, sometimes an ampersand
        cut = $urandom_range(1, body.len() - 1);
        send_item(ChAmp, 1'b0);
        for (int i = 0; i < cut; i++) send_item(body[i], 1'b0);
        b = ($urandom_range(0, 3) == 0) ? ChAmp : 8'($urandom_range(0, 255));
        send_item(b, 1'b0);
      end else if (pick < 78) begin
        send_item(ChAmp, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 88) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 94) begin
        // stream ends inside an escape
        cut = $urandom_range(0, body.len() - 1);
        if (cut == 0) begin
          send_item(ChAmp, 1'b1);
        end else begin
          send_item(ChAmp, 1'b0);
          for (int i = 0; i < cut; i++) send_item(body[i], i == cut - 1);
        end
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    // drain and settle
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("xml_entity_unescape verification clean");
    end else begin
      $display("xml_entity_unescape verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/xeu_pkg.sv
rtl/xeu_front.sv
rtl/xeu_queue.sv
rtl/xeu_back.sv
rtl/xml_entity_unescape.sv
tb/xml_entity_unescape_tb.sv
